/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the front, queue and back rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define CLE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define CLE_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLE_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* hw/rtl/cle_pkg.sv */
`default_nettype none

package cle_pkg;

	localparam logic OP_EDIT = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic REG_LINE_SIZE = 1'b0;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam logic [7:0] LINE_SIZE_RESET = 8'd128;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} cle_req_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       line_done;
		logic [7:0] line_length;
		logic       last;
	} cle_rsp_t;

	// echo sequence to play out for one queued word
	typedef enum logic [1:0] {
		SEQ_ONE = 2'd0,
		SEQ_BS  = 2'd1,
		SEQ_CR  = 2'd2
	} cle_seq_t;

	typedef struct packed {
		logic       is_read;
		cle_seq_t   seq;
		logic [7:0] data;
		logic       done;
		logic [7:0] length;
	} cle_entry_t;

	typedef struct packed {
		logic       valid;
		cle_entry_t entry;
	} cle_slot_t;

endpackage

`default_nettype wire

/* hw/rtl/cle_ram.sv */
`default_nettype none

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/cle_front.sv */
`default_nettype none

`include "assert_macros.svh"

module cle_front
	import cle_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire cle_req_t          req,
	input  wire logic [7:0]        limit_m1,
	input  wire logic [QCNT_W-1:0] queue_count,
	output cle_slot_t              push
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);
	localparam logic [QCNT_W:0] QFULL = (QCNT_W+1)'(QUEUE_DEPTH);

	logic [7:0] len_q;
	logic       zero_fill_q;
	logic       valid_s1;
	logic       oob_s1;
	cle_entry_t entry_s1;

	logic          accept;
	logic [7:0]    len_inc;
	logic [7:0]    len_dec;
	logic [7:0]    len_next;
	logic [7:0]    wpos;
	logic [7:0]    wdata;
	logic          wr_req;
	logic          done;
	logic          push_next;
	cle_entry_t    entry_next;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	// a line end needs a second store write, so req stalls while it is made
	assign req_stall = zero_fill_q ||
		(({1'b0, queue_count} + (QCNT_W+1)'(valid_s1)) >= QFULL);
	assign accept = req_valid && !req_stall;

	assign len_inc = len_q + 8'd1;
	assign len_dec = len_q - 8'd1;

	always_comb begin
		len_next   = len_q;
		wpos       = len_q;
		wdata      = 8'd0;
		wr_req     = 1'b0;
		done       = 1'b0;
		push_next  = 1'b0;
		entry_next = '{is_read: 1'b0, seq: SEQ_ONE, data: req.rx_byte,
			done: 1'b0, length: 8'd0};
		if (accept) begin
			if (req.operation == OP_READ) begin
				entry_next.is_read = 1'b1;
				push_next = 1'b1;
			end else begin
				case (req.rx_byte)
					CH_BS: begin
						if (len_q != 8'd0) begin
							len_next        = len_dec;
							wpos            = len_dec;
							wr_req          = 1'b1;
							entry_next.seq  = SEQ_BS;
							push_next       = 1'b1;
						end
					end
					CH_CR: begin
						wr_req         = 1'b1;
						done           = 1'b1;
						entry_next.seq = SEQ_CR;
						push_next      = 1'b1;
					end
					CH_TAB: begin
						push_next = 1'b0;
					end
					default: begin
						wdata     = req.rx_byte;
						wr_req    = 1'b1;
						len_next  = len_inc;
						push_next = 1'b1;
						if (len_inc >= limit_m1) begin
							done = 1'b1;
						end
					end
				endcase
				if (done) begin
					entry_next.done   = 1'b1;
					entry_next.length = len_next;
					len_next          = 8'd0;
				end
			end
		end
	end

	assign ram_we    = zero_fill_q || (wr_req && ({1'b0, wpos} < DEPTH9));
	assign ram_waddr = zero_fill_q ? limit_m1[AW-1:0] : wpos[AW-1:0];
	assign ram_wdata = zero_fill_q ? 8'd0 : wdata;

	cle_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept && (req.operation == OP_READ)),
		.raddr (req.read_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= 8'd0;
			zero_fill_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			len_q       <= len_next;
			zero_fill_q <= done;
			valid_s1    <= push_next;
		end
	end

	always_ff @(posedge clk) begin
		if (push_next) begin
			entry_s1 <= entry_next;
			oob_s1   <= {1'b0, req.read_index} >= DEPTH9;
		end
	end

	always_comb begin
		push.valid = valid_s1;
		push.entry = entry_s1;
		if (entry_s1.is_read) begin
			push.entry.data = oob_s1 ? 8'd0 : ram_rdata;
		end
	end

	`CLE_ASSERT(a_fill_follows_line_end, clk, arst_n, zero_fill_q |-> (valid_s1 && entry_s1.done && len_q == 8'd0), "terminator fill without a finished line")
	`CLE_ASSERT(a_line_end_fills, clk, arst_n, (valid_s1 && entry_s1.done) |-> zero_fill_q, "finished line without terminator fill")

endmodule

`default_nettype wire

/* hw/rtl/cle_queue.sv */
`default_nettype none

`include "assert_macros.svh"

module cle_queue
	import cle_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cle_slot_t    push,
	input  wire logic         pop,
	output cle_slot_t         head,
	output logic [QCNT_W-1:0] count
);

	cle_entry_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_q] <= push.entry;
		end
	end

	assign head.valid = cnt_q != '0;
	assign head.entry = slot_q[rd_q];
	assign count      = cnt_q;

	`CLE_NEVER(a_no_overflow, clk, arst_n, push.valid && !pop && cnt_q == QCNT_W'(QUEUE_DEPTH), "push into full queue")
	`CLE_NEVER(a_no_underflow, clk, arst_n, pop && cnt_q == '0, "pop from empty queue")

endmodule

`default_nettype wire

/* hw/rtl/cle_back.sv */
`default_nettype none

`include "assert_macros.svh"

module cle_back
	import cle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cle_slot_t head,
	output logic           pop,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output cle_rsp_t       rsp
);

	logic [1:0] step_q;
	logic       rsp_valid_q;
	cle_rsp_t   rsp_q;

	logic       load;
	logic       is_last;
	logic [7:0] byte_out;

	assign load = !rsp_valid_q || !rsp_stall;

	assign is_last = (head.entry.seq == SEQ_ONE) || (step_q == 2'd2);

	always_comb begin
		case (head.entry.seq)
			SEQ_BS:  byte_out = (step_q == 2'd1) ? CH_SP : CH_BS;
			SEQ_CR:  byte_out = (step_q == 2'd1) ? CH_LF : CH_CR;
			default: byte_out = head.entry.data;
		endcase
	end

	assign pop = load && head.valid && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 2'd0;
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= head.valid;
			if (head.valid) begin
				step_q <= is_last ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			rsp_q.kind        <= head.entry.is_read ? KIND_READ : KIND_ECHO;
			rsp_q.data_byte   <= byte_out;
			rsp_q.line_done   <= is_last && head.entry.done;
			rsp_q.line_length <= (is_last && head.entry.done) ? head.entry.length : 8'd0;
			rsp_q.last        <= is_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// mid-sequence the head word must stay in the queue
	`CLE_ASSERT(a_seq_holds_head, clk, arst_n, (step_q != 2'd0) |-> (head.valid && head.entry.seq != SEQ_ONE), "echo sequence lost its word")

endmodule

`default_nettype wire

/* hw/rtl/console_line_editor.sv */
// console line editor
// req channel (req_valid, req_stall, req): one word per received console byte
// (operation 0) or per store read (operation 1, read_index).
// rsp channel (rsp_valid, rsp_stall, rsp): the echo bytes of an edit word, or
// one read-data word; last marks the final word of each request, and the word
// that ends a line carries line_done and line_length.
// backspace and carriage return give three words, a tab or a backspace on an
// empty line gives none, any other byte or a read gives one.
// a req word passes the front register, queue and back output register.
// throughput: one rsp word per cycle while rsp_stall is low; req takes one
// word per cycle while the four-entry queue between front and back has room,
// and a word that ends a line raises req_stall while the terminator is written.
// the line store is a ram with one write and one read port, touched only by the front, in order.
// apb register 0 (line_size) sets the buffer size, reset value 128.
// reset clears the line length, queue and output valid; the store content
// is undefined until written.
// while rsp_stall is high the output word holds and the queue fills; once it
// is full req_stall rises.
`default_nettype none

module console_line_editor
	import cle_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire cle_req_t    req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output cle_rsp_t         rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

	logic [7:0]        line_size_q;
	logic [8:0]        limit;
	logic [7:0]        limit_m1;
	cle_slot_t         push;
	cle_slot_t         head;
	logic              pop;
	logic [QCNT_W-1:0] queue_count;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_size_q <= LINE_SIZE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_LINE_SIZE) begin
			line_size_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_LINE_SIZE) ? {24'd0, line_size_q} : 32'd0;

	// size clamped to the store, and at least two
	always_comb begin
		if (line_size_q < 8'd2) begin
			limit = 9'd2;
		end else if ({1'b0, line_size_q} > DEPTH9) begin
			limit = DEPTH9;
		end else begin
			limit = {1'b0, line_size_q};
		end
	end

	assign limit_m1 = 8'(limit - 9'd1);

	cle_front #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.limit_m1    (limit_m1),
		.queue_count (queue_count),
		.push        (push)
	);

	cle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (queue_count)
	);

	cle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
